// File: rtl/ffra_pkg.sv
// Shared constants for the first-fit register run allocator.
package ffra_pkg;

	localparam int LEN_W    = 8;
	localparam int ADDR_W   = 17;
	localparam int BASE_W   = 16;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_REGS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE    = 2'd2;

endpackage

// File: rtl/first_fit_register_run_allocator.sv
// Top level: occupancy memory, first-fit scan sequencer and result register.
// Allocate: a scan reads one bit a cycle from the occupancy memory port, then one bit is
// written a cycle for the run.
// Free: a bounds check, then a verify pass, then a clear pass.
// One item at a time, next transfer the cycle after the result loads; a result may wait.
// After reset the map is cleared one entry a cycle until every entry is clear; in_ready stays low.
module first_fit_register_run_allocator #(
	parameter int NUM_REGISTERS = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [ffra_pkg::BASE_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [ffra_pkg::LEN_W-1:0]     run_length,
	input  logic [ffra_pkg::ADDR_W-1:0]    free_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ffra_pkg::STATUS_W-1:0]  status,
	output logic [ffra_pkg::ADDR_W-1:0]    granted_address
);

	localparam int IW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
	localparam int CW = $clog2(NUM_REGISTERS + 1);
	localparam logic [CW-1:0] LAST_IDX = CW'(NUM_REGISTERS - 1);
	localparam logic [CW-1:0] NUM_C    = CW'(NUM_REGISTERS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ASCAN,
		S_AMARK,
		S_FCHECK,
		S_FVERIFY,
		S_FCLEAR,
		S_REPLY
	} state_t;

	state_t st_q;

	logic [ffra_pkg::BASE_W-1:0]   base_q;
	logic [CW-1:0]                 idx_q;
	logic [CW-1:0]                 last_q;
	logic [CW-1:0]                 pidx_s1;
	logic                          pv_s1;
	logic                          rd_s1;
	logic [ffra_pkg::LEN_W-1:0]    len_q;
	logic [ffra_pkg::LEN_W-1:0]    run_q;
	logic [ffra_pkg::ADDR_W-1:0]   addr_q;
	logic [ffra_pkg::STATUS_W-1:0] pend_status_q;
	logic [ffra_pkg::ADDR_W-1:0]   pend_addr_q;
	logic                          out_valid_q;
	logic [ffra_pkg::STATUS_W-1:0] status_q;
	logic [ffra_pkg::ADDR_W-1:0]   granted_q;

	logic mem_q [NUM_REGISTERS];
	logic          mem_we;
	logic          mem_wdata;
	logic [IW-1:0] mem_waddr;
	logic [IW-1:0] mem_raddr;

	logic                        scan_st;
	logic [ffra_pkg::LEN_W-1:0]  run_next;
	logic [CW-1:0]               first_c;
	logic [ffra_pkg::ADDR_W-1:0] first_full;
	logic                        free_bad;
	logic                        out_free;

	assign in_ready        = (st_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;

	assign scan_st   = (st_q == S_ASCAN) || (st_q == S_FVERIFY);
	assign mem_we    = (st_q == S_CLEAR) || (st_q == S_AMARK) || (st_q == S_FCLEAR);
	assign mem_wdata = (st_q == S_AMARK);
	assign mem_waddr = idx_q[IW-1:0];
	assign mem_raddr = (idx_q < NUM_C) ? idx_q[IW-1:0] : '0;

	assign run_next = rd_s1 ? '0 : run_q + 8'd1;
	assign first_c  = pidx_s1 + CW'(1) - CW'(len_q);
	assign out_free = !out_valid_q || out_ready;

	assign first_full = addr_q - ffra_pkg::ADDR_W'(base_q);
	assign free_bad   = (len_q == '0)
		|| (addr_q < ffra_pkg::ADDR_W'(base_q))
		|| (first_full >= ffra_pkg::ADDR_W'(NUM_REGISTERS))
		|| ((18'(first_full) + 18'(len_q)) > 18'(NUM_REGISTERS));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLEAR;
			base_q      <= '0;
			idx_q       <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				base_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			pidx_s1 <= idx_q;
			pv_s1   <= scan_st && (idx_q <= last_q);
			case (st_q)
				S_CLEAR: begin
					if (idx_q == LAST_IDX) begin
						st_q <= S_IDLE;
					end
					idx_q <= idx_q + CW'(1);
				end
				S_IDLE: begin
					if (in_valid) begin
						len_q  <= run_length;
						addr_q <= free_address;
						idx_q  <= '0;
						run_q  <= '0;
						last_q <= LAST_IDX;
						if (action) begin
							st_q <= S_FCHECK;
						end else if (run_length == '0 || int'(run_length) > NUM_REGISTERS) begin
							pend_status_q <= ffra_pkg::ST_OUT_OF_REGS;
							pend_addr_q   <= '0;
							st_q          <= S_REPLY;
						end else begin
							st_q <= S_ASCAN;
						end
					end
				end
				S_ASCAN: begin
					if (idx_q <= last_q) begin
						idx_q <= idx_q + CW'(1);
					end
					if (pv_s1) begin
						run_q <= run_next;
						if (run_next == len_q) begin
							idx_q         <= first_c;
							last_q        <= pidx_s1;
							pend_status_q <= ffra_pkg::ST_OK;
							pend_addr_q   <= ffra_pkg::ADDR_W'(base_q)
								+ ffra_pkg::ADDR_W'(first_c);
							st_q          <= S_AMARK;
						end else if (pidx_s1 == LAST_IDX) begin
							pend_status_q <= ffra_pkg::ST_OUT_OF_REGS;
							pend_addr_q   <= '0;
							st_q          <= S_REPLY;
						end
					end
				end
				S_AMARK: begin
					if (idx_q == last_q) begin
						st_q <= S_REPLY;
					end
					idx_q <= idx_q + CW'(1);
				end
				S_FCHECK: begin
					pend_addr_q <= '0;
					if (free_bad) begin
						pend_status_q <= ffra_pkg::ST_BAD_FREE;
						st_q          <= S_REPLY;
					end else begin
						idx_q  <= CW'(first_full);
						last_q <= CW'(first_full + ffra_pkg::ADDR_W'(len_q) - 17'd1);
						st_q   <= S_FVERIFY;
					end
				end
				S_FVERIFY: begin
					if (idx_q <= last_q) begin
						idx_q <= idx_q + CW'(1);
					end
					if (pv_s1) begin
						if (!rd_s1) begin
							pend_status_q <= ffra_pkg::ST_BAD_FREE;
							st_q          <= S_REPLY;
						end else if (pidx_s1 == last_q) begin
							idx_q <= last_q + CW'(1) - CW'(len_q);
							st_q  <= S_FCLEAR;
						end
					end
				end
				S_FCLEAR: begin
					if (idx_q == last_q) begin
						pend_status_q <= ffra_pkg::ST_OK;
						st_q          <= S_REPLY;
					end
					idx_q <= idx_q + CW'(1);
				end
				S_REPLY: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= pend_status_q;
						granted_q   <= pend_addr_q;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/ffra_checker.sv
// Port-level checks for the allocator, bound to the top level.
module ffra_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [ffra_pkg::STATUS_W-1:0]  status,
	input logic [ffra_pkg::ADDR_W-1:0]    granted_address
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_address))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ffra_pkg::ST_OK) || (status == ffra_pkg::ST_OUT_OF_REGS)
			|| (status == ffra_pkg::ST_BAD_FREE))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ffra_pkg::ST_OK |-> granted_address == '0)
		else $error("failed request carries an address");

	// one item in flight: after a transfer the input side closes
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");

endmodule

bind first_fit_register_run_allocator ffra_checker u_ffra_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.granted_address (granted_address)
);
